// ===== rtl/i2cee_pkg.sv =====
// Shared types and constants for the I2C EEPROM byte master.
// Holds the bus phase enum, command codes, register indexes and beat structs.
// No dependencies; compile first.
package i2cee_pkg;

	// Command codes carried in the op field
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_PROBE = 2'd3;

	// Configuration register map
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY  = 1'd1;

	localparam logic [7:0] DEVICE_RESET = 8'hA0;
	localparam logic [3:0] RETRY_RESET  = 4'd10;

	// Index of the last byte in a write (device, address, data)
	localparam logic [1:0] LAST_BYTE = 2'd2;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST0, PH_ST1, PH_ST2, PH_ST3,
		PH_TX0, PH_TX1, PH_TX2,
		PH_AK0, PH_AK1, PH_AKOK, PH_AKNO,
		PH_RX0, PH_RX1, PH_RX2,
		PH_SP0, PH_SP1, PH_SP2
	} phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] mem_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       bus_bad;
		logic       mem_bad;
	} result_t;

	typedef struct packed {
		logic [7:0] device_write_byte;
		logic [3:0] retry_limit;
	} cfg_t;

	typedef struct packed {
		logic idle;
	} status_t;

	// Byte that goes out next on the bus for a given byte position
	function automatic logic [7:0] send_byte(
		input logic [1:0] idx,
		input logic [1:0] cmd,
		input logic [7:0] addr,
		input logic [7:0] data,
		input logic [7:0] dev
	);
		logic [7:0] b;
		if (idx == 2'd0) begin
			b = dev;
		end else if (idx == 2'd1) begin
			b = addr;
		end else if (cmd == OP_WRITE) begin
			b = data;
		end else begin
			b = dev + 8'd1;
		end
		return b;
	endfunction

endpackage

// ===== rtl/i2cee_if.sv =====
// Valid/ready channel interfaces for the I2C EEPROM byte master.
// Item channel carries one tick or command beat; result channel carries bus levels and flags.
// No dependencies.
interface i2cee_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] mem_addr;
	logic [7:0] write_data;
	logic       sda_in;

	modport source(output valid, op, mem_addr, write_data, sda_in, input ready);
	modport sink(input valid, op, mem_addr, write_data, sda_in, output ready);
endinterface

interface i2cee_result_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_out;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       bus_bad;
	logic       mem_bad;

	modport source(output valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
		bus_bad, mem_bad, input ready);
	modport sink(input valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
		bus_bad, mem_bad, output ready);
endinterface

// ===== rtl/i2cee_core.sv =====
// Phase sequencer of the I2C EEPROM byte master: one bus phase per accepted beat.
// Holds command state, shift registers, retry count and flags.
// Depends on i2cee_pkg.
module i2cee_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  i2cee_pkg::item_t  itm,
	input  i2cee_pkg::cfg_t   cfg,
	output i2cee_pkg::result_t res,
	output i2cee_pkg::status_t stat
);
	import i2cee_pkg::*;

	phase_t     phase_q, phase_d, cur;
	logic [1:0] cmd_q, cmd_d, cmd_e;
	logic [1:0] bi_q, bi_d, bi_e;
	logic [3:0] bc_q, bc_d, bc_e, bc_inc;
	logic [7:0] shift_q, shift_d;
	logic [7:0] rd_q, rd_d;
	logic [7:0] addr_q, addr_d, addr_e;
	logic [7:0] data_q, data_d, data_e;
	logic [3:0] fail_q, fail_d, fail_e;
	logic       busbad_q, busbad_d;
	logic       membad_q, membad_d;
	logic       start;

	// Hold state; advance one phase per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cmd_q    <= OP_TICK;
			bi_q     <= '0;
			bc_q     <= '0;
			shift_q  <= '0;
			rd_q     <= '0;
			addr_q   <= '0;
			data_q   <= '0;
			fail_q   <= '0;
			busbad_q <= 1'b0;
			membad_q <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			cmd_q    <= cmd_d;
			bi_q     <= bi_d;
			bc_q     <= bc_d;
			shift_q  <= shift_d;
			rd_q     <= rd_d;
			addr_q   <= addr_d;
			data_q   <= data_d;
			fail_q   <= fail_d;
			busbad_q <= busbad_d;
			membad_q <= membad_d;
		end
	end

	// Next phase and bus levels for this beat
	always_comb begin
		start  = (phase_q == PH_IDLE) && (itm.op != OP_TICK);
		cmd_e  = start ? itm.op : cmd_q;
		addr_e = start ? itm.mem_addr : addr_q;
		data_e = start ? itm.write_data : data_q;
		bi_e   = start ? 2'd0 : bi_q;
		bc_e   = start ? 4'd0 : bc_q;
		fail_e = start ? 4'd0 : fail_q;
		cur    = start ? PH_ST0 : phase_q;
		bc_inc = bc_e + 4'd1;

		phase_d  = cur;
		cmd_d    = cmd_e;
		addr_d   = addr_e;
		data_d   = data_e;
		bi_d     = bi_e;
		bc_d     = bc_e;
		shift_d  = shift_q;
		rd_d     = rd_q;
		fail_d   = fail_e;
		busbad_d = busbad_q;
		membad_d = membad_q;

		res = '0;
		res.scl      = 1'b1;
		res.sda_out  = 1'b1;
		res.busy_res = 1'b1;

		unique case (cur)
			PH_ST0: begin
				res.scl = 1'b0; res.sda_drive = 1'b1; phase_d = PH_ST1;
			end
			PH_ST1: begin
				res.sda_drive = 1'b1; phase_d = PH_ST2;
			end
			PH_ST2: begin
				res.sda_out = 1'b0; res.sda_drive = 1'b1; phase_d = PH_ST3;
			end
			PH_ST3: begin
				res.scl = 1'b0; res.sda_out = 1'b0; res.sda_drive = 1'b1;
				shift_d = send_byte(bi_e, cmd_e, addr_e, data_e, cfg.device_write_byte);
				bc_d    = 4'd0;
				phase_d = PH_TX0;
			end
			PH_TX0: begin
				res.scl = 1'b0; res.sda_out = shift_q[7]; res.sda_drive = 1'b1;
				phase_d = PH_TX1;
			end
			PH_TX1: begin
				res.sda_out = shift_q[7]; res.sda_drive = 1'b1;
				phase_d = PH_TX2;
			end
			PH_TX2: begin
				res.scl = 1'b0; res.sda_out = shift_q[7]; res.sda_drive = 1'b1;
				shift_d = {shift_q[6:0], 1'b0};
				bc_d    = bc_inc;
				phase_d = (bc_inc >= BITS_PER_BYTE) ? PH_AK0 : PH_TX0;
			end
			PH_AK0: begin
				res.scl = 1'b0; res.sda_out = 1'b0; phase_d = PH_AK1;
			end
			PH_AK1: begin
				res.sda_out = 1'b0;
				phase_d = itm.sda_in ? PH_AKNO : PH_AKOK;
			end
			PH_AKOK: begin
				res.scl = 1'b0; res.sda_out = 1'b0;
				if (cmd_e == OP_PROBE) begin
					membad_d = 1'b0;
					phase_d  = PH_SP0;
				end else if (cmd_e == OP_WRITE) begin
					if (bi_e >= LAST_BYTE) begin
						busbad_d = 1'b0;
						fail_d   = 4'd0;
						phase_d  = PH_SP0;
					end else begin
						bi_d    = bi_e + 2'd1;
						shift_d = send_byte(bi_e + 2'd1, cmd_e, addr_e, data_e,
							cfg.device_write_byte);
						bc_d    = 4'd0;
						phase_d = PH_TX0;
					end
				end else begin
					if (bi_e == 2'd0) begin
						bi_d    = 2'd1;
						shift_d = send_byte(2'd1, cmd_e, addr_e, data_e,
							cfg.device_write_byte);
						bc_d    = 4'd0;
						phase_d = PH_TX0;
					end else if (bi_e == 2'd1) begin
						// repeated start, then device address for read
						bi_d    = LAST_BYTE;
						phase_d = PH_ST0;
					end else begin
						bc_d    = 4'd0;
						shift_d = 8'd0;
						phase_d = PH_RX0;
					end
				end
			end
			PH_AKNO: begin
				res.scl = 1'b0; res.sda_out = 1'b0;
				if (cmd_e == OP_PROBE) begin
					membad_d = 1'b1;
					phase_d  = PH_SP0;
				end else if (fail_e >= cfg.retry_limit) begin
					// give up and release the bus
					fail_d   = 4'd0;
					busbad_d = 1'b1;
					phase_d  = PH_SP0;
				end else begin
					fail_d  = fail_e + 4'd1;
					bi_d    = 2'd0;
					phase_d = PH_ST0;
				end
			end
			PH_RX0: begin
				res.scl = 1'b0; res.sda_out = 1'b0; phase_d = PH_RX1;
			end
			PH_RX1: begin
				res.sda_out = 1'b0;
				shift_d = {shift_q[6:0], itm.sda_in};
				phase_d = PH_RX2;
			end
			PH_RX2: begin
				res.scl = 1'b0; res.sda_out = 1'b0;
				bc_d = bc_inc;
				if (bc_inc >= BITS_PER_BYTE) begin
					rd_d     = shift_q;
					busbad_d = 1'b0;
					fail_d   = 4'd0;
					phase_d  = PH_SP0;
				end else begin
					phase_d = PH_RX0;
				end
			end
			PH_SP0: begin
				res.scl = 1'b0; res.sda_out = 1'b0; res.sda_drive = 1'b1;
				phase_d = PH_SP1;
			end
			PH_SP1: begin
				res.sda_out = 1'b0; res.sda_drive = 1'b1; phase_d = PH_SP2;
			end
			PH_SP2: begin
				res.sda_drive = 1'b1; res.done_res = 1'b1; phase_d = PH_IDLE;
			end
			default: begin
				res.busy_res = 1'b0;
				phase_d = PH_IDLE;
			end
		endcase

		res.read_data = rd_d;
		res.bus_bad   = busbad_d;
		res.mem_bad   = membad_d;
	end

	assign stat.idle = (phase_q == PH_IDLE);

endmodule

// ===== rtl/i2c_eeprom_byte_master.sv =====
// Top level of the I2C EEPROM byte master: input stage, config registers, result register.
// Instantiates i2cee_core; uses i2cee_pkg and the channel interfaces in i2cee_if.sv.
//
// Usage: each beat on the item channel is one bus tick. op selects tick (0), byte
// write (1), random read (2) or probe (3); a command op is taken only while the
// sequencer is idle and otherwise counts as a plain tick. sda_in is the sampled
// SDA level for that tick. Each item beat yields exactly one result beat with the
// SCL/SDA levels for the tick, busy/done status, the last read byte and flags.
// A bit spans three ticks, a start four and a stop three.
// An accepted item waits in the input stage and steps into the result register,
// where it is offered, once that register is empty or being taken. Throughput:
// one item per cycle while the receiver takes results, set by the single phase
// step between the two registers.
// The input stage keeps taking beats while a finished result waits; when the
// receiver stalls, the result register and then the input stage hold, and
// ready drops only once both are full.
// Reset: arst_n clears both stages, the sequencer to idle with flags clear, and
// the registers to device byte 0xA0 and retry limit 10. Write the registers
// only while the block is idle.
module i2c_eeprom_byte_master (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [i2cee_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [i2cee_pkg::CFG_DATA_W-1:0]    cfg_data,
	i2cee_item_if.sink                          item,
	i2cee_result_if.source                      result
);
	import i2cee_pkg::*;

	cfg_t      cfg_q;
	item_t     item_s1;
	logic      valid_s1;
	result_t   res_q;
	logic      res_valid_q;
	result_t   step;
	status_t   core_stat;
	logic      adv;

	// Move a beat from the input stage to the result register
	assign adv        = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_write_byte <= DEVICE_RESET;
			cfg_q.retry_limit       <= RETRY_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_DEVICE) begin
				cfg_q.device_write_byte <= cfg_data;
			end
			if (cfg_index == CFG_RETRY) begin
				cfg_q.retry_limit <= cfg_data[3:0];
			end
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{op: item.op, mem_addr: item.mem_addr,
				write_data: item.write_data, sda_in: item.sda_in};
		end
	end

	i2cee_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.itm    (item_s1),
		.cfg    (cfg_q),
		.res    (step),
		.stat   (core_stat)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= step;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.scl       = res_q.scl;
	assign result.sda_out   = res_q.sda_out;
	assign result.sda_drive = res_q.sda_drive;
	assign result.busy_res  = res_q.busy_res;
	assign result.done_res  = res_q.done_res;
	assign result.read_data = res_q.read_data;
	assign result.bus_bad   = res_q.bus_bad;
	assign result.mem_bad   = res_q.mem_bad;

`ifndef ASSERT_OFF
	// Both stages full and stalled: no new beat may enter
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid_q && !result.ready) |-> !item.ready)
		else $error("item accepted while both stages are full");

	// The stop tick that finishes a command returns the sequencer to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && step.done_res) |=> core_stat.idle)
		else $error("sequencer not idle after done");

	// Any tick stepped while a command runs reports busy
	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !core_stat.idle) |-> step.busy_res)
		else $error("busy dropped inside a command");
`endif

endmodule

// ===== tb/sv/tb_i2c_eeprom_byte_master.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for i2c_eeprom_byte_master: drives bus ticks and commands
// with random slave responses and compares every result beat against a bus sequencer model.
// Depends on i2cee_pkg and the channel interfaces in i2cee_if.sv.
module tb_i2c_eeprom_byte_master;
	import i2cee_pkg::*;

	// Sequencer state as the model keeps it
	typedef struct packed {
		phase_t     ph;
		logic [1:0] cmd;
		logic [1:0] byte_idx;
		logic [3:0] nbits;
		logic [7:0] sh;
		logic [7:0] rd;
		logic [7:0] addr;
		logic [7:0] data;
		logic [3:0] fails;
		logic       bus_bad;
		logic       mem_bad;
	} seq_state_t;

	localparam int unsigned TICKS_PER_SETTING = 190;
	localparam int unsigned NUM_SETTINGS = 5;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	i2cee_item_if   item_ch();
	i2cee_result_if res_ch();

	i2c_eeprom_byte_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (res_ch)
	);

	// Register copies shared by both sequencer models
	logic [7:0] dev_cfg;
	logic [3:0] retry_cfg;

	// plan_seq runs ahead while ticks are generated; bus_seq follows accepted beats
	seq_state_t plan_seq;
	seq_state_t bus_seq;

	item_t   tick_q[$];
	result_t bus_levels_q[$];
	item_t   offered;
	result_t seen;
	result_t expected_res;

	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned n_accepted;
	int unsigned n_results;
	int unsigned n_mismatch;
	int unsigned n_cmd_ticks;
	int unsigned n_cmds [4];

	logic [15:0] stall_pat;
	int unsigned pat_left;
	int unsigned hold_left;
	int unsigned holds_done;

	// Load the next byte to shift out onto the bus
	function automatic void load_byte(inout seq_state_t s);
		if (s.byte_idx == 2'd0) begin
			s.sh = dev_cfg;
		end else if (s.byte_idx == 2'd1) begin
			s.sh = s.addr;
		end else if (s.cmd == OP_WRITE) begin
			s.sh = s.data;
		end else begin
			s.sh = dev_cfg + 8'd1;
		end
		s.nbits = '0;
		s.ph = PH_TX0;
	endfunction

	// Advance the sequencer by one tick and return the bus levels and flags of that tick
	function automatic void bus_step(inout seq_state_t s, input item_t it, output result_t r);
		r = '0;
		r.scl = 1'b1;
		r.sda_out = 1'b1;
		r.busy_res = 1'b1;
		if (s.ph == PH_IDLE && it.op != OP_TICK) begin
			s.cmd = it.op;
			s.addr = it.mem_addr;
			s.data = it.write_data;
			s.byte_idx = '0;
			s.nbits = '0;
			s.fails = '0;
			s.ph = PH_ST0;
		end
		case (s.ph)
			PH_ST0: begin
				r.scl = 1'b0; r.sda_out = 1'b1; r.sda_drive = 1'b1; s.ph = PH_ST1;
			end
			PH_ST1: begin
				r.scl = 1'b1; r.sda_out = 1'b1; r.sda_drive = 1'b1; s.ph = PH_ST2;
			end
			PH_ST2: begin
				r.scl = 1'b1; r.sda_out = 1'b0; r.sda_drive = 1'b1; s.ph = PH_ST3;
			end
			PH_ST3: begin
				r.scl = 1'b0; r.sda_out = 1'b0; r.sda_drive = 1'b1;
				load_byte(s);
			end
			PH_TX0: begin
				r.scl = 1'b0; r.sda_out = s.sh[7]; r.sda_drive = 1'b1; s.ph = PH_TX1;
			end
			PH_TX1: begin
				r.scl = 1'b1; r.sda_out = s.sh[7]; r.sda_drive = 1'b1; s.ph = PH_TX2;
			end
			PH_TX2: begin
				r.scl = 1'b0; r.sda_out = s.sh[7]; r.sda_drive = 1'b1;
				s.sh = {s.sh[6:0], 1'b0};
				s.nbits = s.nbits + 4'd1;
				s.ph = (s.nbits >= BITS_PER_BYTE) ? PH_AK0 : PH_TX0;
			end
			PH_AK0: begin
				r.scl = 1'b0; r.sda_out = 1'b0; s.ph = PH_AK1;
			end
			PH_AK1: begin
				r.scl = 1'b1; r.sda_out = 1'b0;
				s.ph = it.sda_in ? PH_AKNO : PH_AKOK;
			end
			PH_AKOK: begin
				r.scl = 1'b0; r.sda_out = 1'b0;
				if (s.cmd == OP_PROBE) begin
					s.mem_bad = 1'b0;
					s.ph = PH_SP0;
				end else if (s.cmd == OP_WRITE) begin
					if (s.byte_idx >= LAST_BYTE) begin
						s.bus_bad = 1'b0;
						s.fails = '0;
						s.ph = PH_SP0;
					end else begin
						s.byte_idx = s.byte_idx + 2'd1;
						load_byte(s);
					end
				end else if (s.byte_idx == 2'd0) begin
					s.byte_idx = 2'd1;
					load_byte(s);
				end else if (s.byte_idx == 2'd1) begin
					// repeated start before the device address for read
					s.byte_idx = 2'd2;
					s.ph = PH_ST0;
				end else begin
					s.nbits = '0;
					s.sh = '0;
					s.ph = PH_RX0;
				end
			end
			PH_AKNO: begin
				r.scl = 1'b0; r.sda_out = 1'b0;
				if (s.cmd == OP_PROBE) begin
					s.mem_bad = 1'b1;
					s.ph = PH_SP0;
				end else if (s.fails >= retry_cfg) begin
					s.fails = '0;
					s.bus_bad = 1'b1;
					s.ph = PH_SP0;
				end else begin
					s.fails = s.fails + 4'd1;
					s.byte_idx = '0;
					s.ph = PH_ST0;
				end
			end
			PH_RX0: begin
				r.scl = 1'b0; r.sda_out = 1'b0; s.ph = PH_RX1;
			end
			PH_RX1: begin
				r.scl = 1'b1; r.sda_out = 1'b0;
				s.sh = {s.sh[6:0], it.sda_in};
				s.ph = PH_RX2;
			end
			PH_RX2: begin
				r.scl = 1'b0; r.sda_out = 1'b0;
				s.nbits = s.nbits + 4'd1;
				if (s.nbits >= BITS_PER_BYTE) begin
					s.rd = s.sh;
					s.bus_bad = 1'b0;
					s.fails = '0;
					s.ph = PH_SP0;
				end else begin
					s.ph = PH_RX0;
				end
			end
			PH_SP0: begin
				r.scl = 1'b0; r.sda_out = 1'b0; r.sda_drive = 1'b1; s.ph = PH_SP1;
			end
			PH_SP1: begin
				r.scl = 1'b1; r.sda_out = 1'b0; r.sda_drive = 1'b1; s.ph = PH_SP2;
			end
			PH_SP2: begin
				r.scl = 1'b1; r.sda_out = 1'b1; r.sda_drive = 1'b1; r.done_res = 1'b1;
				s.ph = PH_IDLE;
			end
			default: begin
				r.busy_res = 1'b0;
				s.ph = PH_IDLE;
			end
		endcase
		r.read_data = s.rd;
		r.bus_bad = s.bus_bad;
		r.mem_bad = s.mem_bad;
	endfunction

	// Queue one tick and advance the look-ahead sequencer with it
	task automatic queue_tick(input item_t it);
		result_t unused;
		bus_step(plan_seq, it, unused);
		tick_q.push_back(it);
	endtask

	// Slave answer on SDA: acknowledge policy at the ack clock, random level elsewhere
	function automatic logic slave_sda(input int unsigned ack_mode);
		logic level;
		level = 1'($urandom_range(0, 1));
		if (plan_seq.ph == PH_AK1) begin
			case (ack_mode)
				0: level = 1'b0;
				1: level = ($urandom_range(0, 4) == 0);
				default: level = 1'b1;
			endcase
		end
		return level;
	endfunction

	// Queue a whole command, ticking until the sequencer is idle again
	task automatic run_command(input logic [1:0] cmd, input int unsigned ack_mode);
		item_t it;
		bit    first;
		first = 1'b1;
		n_cmds[cmd]++;
		do begin
			if (first) begin
				it.op = cmd;
			end else if ($urandom_range(0, 7) == 0) begin
				// commands issued while busy count as plain ticks
				it.op = 2'($urandom_range(1, 3));
			end else begin
				it.op = OP_TICK;
			end
			it.mem_addr = 8'($urandom);
			it.write_data = 8'($urandom);
			it.sda_in = slave_sda(ack_mode);
			queue_tick(it);
			n_cmd_ticks++;
			first = 1'b0;
		end while (plan_seq.ph != PH_IDLE);
	endtask

	// Queue idle bus ticks with random payload
	task automatic idle_ticks(input int unsigned count);
		item_t it;
		repeat (count) begin
			it.op = OP_TICK;
			it.mem_addr = 8'($urandom);
			it.write_data = 8'($urandom);
			it.sda_in = 1'($urandom_range(0, 1));
			queue_tick(it);
		end
	endtask

	// Hold until every queued tick is accepted and every result beat has arrived
	task automatic wait_drained();
		while (tick_q.size() != 0 || item_ch.valid || bus_levels_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_DEVICE) begin
			dev_cfg = value;
		end else begin
			retry_cfg = value[3:0];
		end
	endtask

	task automatic note_mismatch(input string what, input int unsigned want,
		input int unsigned got);
		n_mismatch++;
		if (n_mismatch <= 10) begin
			$display("[%0t] mismatch on %s at result %0d: expected 0x%0h, got 0x%0h",
				$realtime, what, n_results, want, got);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Give up on a hung run
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Sender: offer queued ticks in bursts with random gaps, predict on each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.op <= OP_TICK;
			item_ch.mem_addr <= '0;
			item_ch.write_data <= '0;
			item_ch.sda_in <= 1'b0;
			burst_left = 8;
			gap_left = 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				bus_step(bus_seq, offered, seen);
				bus_levels_q.push_back(seen);
				n_accepted++;
			end
			if (item_ch.valid && !item_ch.ready) begin
				// hold the beat until taken
			end else if (gap_left != 0) begin
				gap_left--;
				item_ch.valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				offered = tick_q.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.op <= offered.op;
				item_ch.mem_addr <= offered.mem_addr;
				item_ch.write_data <= offered.write_data;
				item_ch.sda_in <= offered.sda_in;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: stall on a rotating pattern, with two long hold-offs to back up the block
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_pat <= '1;
			pat_left <= 0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && n_results >= 300 + 400 * holds_done) begin
			res_ch.ready <= 1'b0;
			hold_left <= 80;
			holds_done <= holds_done + 1;
		end else if (pat_left == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pat <= '1;
				1: stall_pat <= 16'($urandom);
				2: stall_pat <= 16'($urandom & $urandom);
				default: stall_pat <= 16'($urandom | $urandom);
			endcase
			pat_left <= 48;
			res_ch.ready <= 1'b1;
		end else begin
			res_ch.ready <= stall_pat[0];
			stall_pat <= {stall_pat[0], stall_pat[15:1]};
			pat_left <= pat_left - 1;
		end
	end

	// Monitor: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (bus_levels_q.size() == 0) begin
				note_mismatch("unexpected beat", 0, 1);
			end else begin
				expected_res = bus_levels_q.pop_front();
				if (res_ch.scl !== expected_res.scl)
					note_mismatch("scl", expected_res.scl, res_ch.scl);
				if (res_ch.sda_out !== expected_res.sda_out)
					note_mismatch("sda_out", expected_res.sda_out, res_ch.sda_out);
				if (res_ch.sda_drive !== expected_res.sda_drive)
					note_mismatch("sda_drive", expected_res.sda_drive, res_ch.sda_drive);
				if (res_ch.busy_res !== expected_res.busy_res)
					note_mismatch("busy_res", expected_res.busy_res, res_ch.busy_res);
				if (res_ch.done_res !== expected_res.done_res)
					note_mismatch("done_res", expected_res.done_res, res_ch.done_res);
				if (res_ch.read_data !== expected_res.read_data)
					note_mismatch("read_data", expected_res.read_data, res_ch.read_data);
				if (res_ch.bus_bad !== expected_res.bus_bad)
					note_mismatch("bus_bad", expected_res.bus_bad, res_ch.bus_bad);
				if (res_ch.mem_bad !== expected_res.mem_bad)
					note_mismatch("mem_bad", expected_res.mem_bad, res_ch.mem_bad);
			end
			n_results <= n_results + 1;
		end
	end

	// Stimulus: directed opening, then random commands under several register settings
	initial begin
		int unsigned setting;
		int unsigned k;
		int unsigned target;
		logic [1:0]  cmd;
		item_t       it;
		logic [7:0]  dev_pick;
		logic [3:0]  retry_pick;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_TICK;
		item_ch.mem_addr = '0;
		item_ch.write_data = '0;
		item_ch.sda_in = 1'b0;
		res_ch.ready = 1'b0;
		dev_cfg = DEVICE_RESET;
		retry_cfg = RETRY_RESET;
		plan_seq = '0;
		plan_seq.ph = PH_IDLE;
		bus_seq = plan_seq;
		n_accepted = 0;
		n_results = 0;
		n_mismatch = 0;
		n_cmd_ticks = 0;
		n_cmds = '{default: 0};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Idle ticks at the field extremes, then a probe that gets no acknowledge
		it = '{op: OP_TICK, mem_addr: 8'h00, write_data: 8'h00, sda_in: 1'b0};
		queue_tick(it);
		it = '{op: OP_TICK, mem_addr: 8'hFF, write_data: 8'hFF, sda_in: 1'b1};
		queue_tick(it);
		run_command(OP_PROBE, 2);
		idle_ticks(2);

		for (setting = 0; setting < NUM_SETTINGS; setting++) begin
			if (setting != 0) begin
				wait_drained();
				case (setting)
					1: begin dev_pick = 8'hFF; retry_pick = 4'd0; end
					2: begin dev_pick = 8'h00; retry_pick = 4'd15; end
					3: begin
						dev_pick = 8'($urandom_range(0, 254));
						retry_pick = 4'($urandom_range(1, 14));
					end
					default: begin dev_pick = 8'hFE; retry_pick = 4'd1; end
				endcase
				write_reg(CFG_DEVICE, dev_pick);
				write_reg(CFG_RETRY, retry_pick);
			end
			// Mostly clean transfers, some with scattered NACKs, a few never acknowledged
			target = n_cmd_ticks + TICKS_PER_SETTING;
			k = 0;
			while (n_cmd_ticks < target) begin
				idle_ticks($urandom_range(0, 3));
				cmd = (k < 3) ? 2'(k + 1) : 2'($urandom_range(1, 3));
				case ($urandom_range(0, 9))
					0: run_command(cmd, 2);
					1, 2, 3: run_command(cmd, 1);
					default: run_command(cmd, 0);
				endcase
				k++;
			end
		end
		wait_drained();
		repeat (8) @(negedge clk);

		$display("Run covered %0d bus ticks and %0d commands (%0d writes, %0d reads, %0d probes)",
			n_accepted, n_cmds[OP_WRITE] + n_cmds[OP_READ] + n_cmds[OP_PROBE],
			n_cmds[OP_WRITE], n_cmds[OP_READ], n_cmds[OP_PROBE]);
		$display("under %0d register settings with %0d long receiver hold-offs",
			NUM_SETTINGS, holds_done);
		if (n_mismatch == 0 && bus_levels_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/i2cee_pkg.sv
rtl/i2cee_if.sv
rtl/i2cee_core.sv
rtl/i2c_eeprom_byte_master.sv
tb/sv/tb_i2c_eeprom_byte_master.sv
